@@ rtl/core/kwm_pkg.sv @@
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types, codes and defaults of the timestamp merge unit.
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int THREADS_DEF     = 8;
  localparam int QUEUE_DEPTH_DEF = 256;
  localparam int RATIO_FRAC_DEF  = 16;

  localparam int STAMP_W  = 64;
  localparam int WORD_W   = 32;
  localparam int TIDX_W   = 3;
  localparam int TNUM_W   = 4;
  localparam int TCNT_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 64;

  // beat widths, padded up to whole bytes
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 136;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THREAD_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_STAMP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NS_RATIO     = 2'd2;

  // request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_LOADED    = 2'd0,
    ST_REJECTED  = 2'd1,
    ST_DELIVERED = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // one stored event
  typedef struct packed {
    logic [WORD_W-1:0]  value;
    logic [WORD_W-1:0]  kind;
    logic [STAMP_W-1:0] stamp;
  } event_t;

  localparam int EVENT_W = $bits(event_t);

endpackage

@@ rtl/core/kwm_ram.sv @@
// ----------------------------------------------------------------------------
// kwm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module kwm_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/kwm_scale.sv @@
// ----------------------------------------------------------------------------
// kwm_scale
// Tick to nanosecond conversion: ((stamp - base) * ratio) >> RATIO_FRAC,
// saturated to 64 bits, through one shared 32x32 multiplier over five steps.
// ----------------------------------------------------------------------------
module kwm_scale #(
  parameter int RATIO_FRAC = kwm_pkg::RATIO_FRAC_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [kwm_pkg::STAMP_W-1:0] stamp,
  input  logic [kwm_pkg::STAMP_W-1:0] base,
  input  logic [kwm_pkg::WORD_W-1:0]  ratio,
  output logic                        done,
  output logic [kwm_pkg::STAMP_W-1:0] ns
);

  localparam int SW      = kwm_pkg::STAMP_W;
  localparam int WW      = kwm_pkg::WORD_W;
  localparam int PROD_W  = SW + WW;
  localparam int SAT_LSB = SW + RATIO_FRAC;

  logic [4:0]        stg_r;
  logic [SW-1:0]     delta_r;
  logic [SW-1:0]     lo_r;
  logic [SW-1:0]     mid_r;
  logic [PROD_W-1:0] prod_r;
  logic [SW-1:0]     ns_r;

  logic [WW-1:0]     mul_a;
  logic [SW-1:0]     mul_p;
  logic [PROD_W-1:0] sat_bits;

  // low half first, then high half through the same multiplier
  assign mul_a    = stg_r[0] ? delta_r[WW-1:0] : delta_r[SW-1:WW];
  assign mul_p    = SW'(mul_a) * SW'(ratio);
  assign sat_bits = prod_r >> SAT_LSB;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r <= '0;
    end else begin
      stg_r <= {stg_r[3:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      delta_r <= stamp - base;
    end
    if (stg_r[0]) begin
      lo_r <= mul_p;
    end
    if (stg_r[1]) begin
      mid_r <= mul_p;
    end
    if (stg_r[2]) begin
      prod_r <= {mid_r, {WW{1'b0}}} + PROD_W'(lo_r);
    end
    if (stg_r[3]) begin
      ns_r <= (sat_bits != '0) ? {SW{1'b1}} : prod_r[RATIO_FRAC +: SW];
    end
  end

  assign done = stg_r[4];
  assign ns   = ns_r;

endmodule

@@ rtl/core/kway_timestamp_merge_unit.sv @@
// ----------------------------------------------------------------------------
// kway_timestamp_merge_unit
// Per-thread event queues in one RAM, merged in timestamp order on request.
// ----------------------------------------------------------------------------
//  channel | ports                         | content
//  --------+-------------------------------+-------------------------------------
//  in      | in_tvalid/in_tready           | tuser: req_type; tdata: request
//  out     | out_tvalid/out_tready         | tuser: status; tdata: result
//  cfg     | cfg_valid/cfg_ready           | cfg_index, cfg_data register write
//
//  a load goes from the load state to the output state; a pop scans the
//  heads, reading one RAM entry per non-empty queue of the threads in use,
//  then runs a five-step conversion on one 32x32 multiplier (skipped when
//  all queues are empty); the next request is taken back in idle. a result held by out_tready
//  stalls only the next result; reset clears the queue pointers and loads
//  the register defaults, the event RAM needs no clearing.
// ----------------------------------------------------------------------------
module kway_timestamp_merge_unit #(
  parameter int THREADS     = kwm_pkg::THREADS_DEF,
  parameter int QUEUE_DEPTH = kwm_pkg::QUEUE_DEPTH_DEF,
  parameter int RATIO_FRAC  = kwm_pkg::RATIO_FRAC_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: thread_index, timestamp, event_type, event_value, zero pad
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [kwm_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser: req_type
  input  logic [0:0]                        in_tuser,
  // out_tdata: thread_number, ns_time, out_type, out_value, zero pad
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [kwm_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // out_tuser: status
  output logic [1:0]                        out_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kwm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kwm_pkg::CFG_W-1:0]         cfg_data
);

  localparam int SW        = kwm_pkg::STAMP_W;
  localparam int WW        = kwm_pkg::WORD_W;
  localparam int TW        = $clog2(THREADS);
  localparam int CW        = $clog2(THREADS + 1);
  localparam int PW        = $clog2(QUEUE_DEPTH);
  localparam int FW        = $clog2(QUEUE_DEPTH + 1);
  localparam int AW        = TW + PW;
  localparam int MEM_DEPTH = THREADS * (2 ** PW);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_SCALE = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [kwm_pkg::TCNT_W-1:0] thr_cnt_r;
  logic [SW-1:0]              start_r;
  logic [WW-1:0]              ratio_r;
  logic [CW-1:0]              cnt;

  // captured request
  logic [kwm_pkg::TIDX_W-1:0]    req_thread_r;
  kwm_pkg::event_t               req_ev_r;

  // queue pointers
  logic [PW-1:0] head_r [THREADS];
  logic [FW-1:0] fill_r [THREADS];
  logic [TW-1:0] ptr_idx;
  logic [PW-1:0] ptr_head;
  logic [FW-1:0] ptr_fill;

  // scan
  logic [CW-1:0]   scan_idx_r;
  logic            pend_valid_r;
  logic [TW-1:0]   pend_idx_r;
  logic [PW-1:0]   pend_head_r;
  logic [FW-1:0]   pend_fill_r;
  logic            found_r;
  logic [TW-1:0]   best_idx_r;
  logic [PW-1:0]   best_head_r;
  logic [FW-1:0]   best_fill_r;
  kwm_pkg::event_t best_ev_r;
  logic            take;

  // load path
  logic          ld_ok;
  logic [FW:0]   pos_sum;
  logic [PW-1:0] wr_pos;

  // ram
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic                       ram_re;
  logic [AW-1:0]              ram_raddr;
  logic [kwm_pkg::EVENT_W-1:0] ram_rdata;
  kwm_pkg::event_t            rd_ev;

  // scaler
  logic          sc_start;
  logic          sc_done;
  logic [SW-1:0] sc_ns;

  // result
  kwm_pkg::status_t            res_status_r;
  logic [kwm_pkg::TNUM_W-1:0]  res_thread_r;
  logic [SW-1:0]               res_ns_r;
  logic [WW-1:0]               res_type_r;
  logic [WW-1:0]               res_value_r;
  logic                        out_valid_r;
  logic [kwm_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic [1:0]                  out_user_r;
  logic                        out_free;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_cnt_r <= kwm_pkg::TCNT_W'(1);
      start_r   <= '0;
      ratio_r   <= WW'(65536);
    end else if (cfg_valid) begin
      case (cfg_index)
        kwm_pkg::REG_THREAD_COUNT: thr_cnt_r <= cfg_data[kwm_pkg::TCNT_W-1:0];
        kwm_pkg::REG_START_STAMP:  start_r   <= cfg_data[SW-1:0];
        kwm_pkg::REG_NS_RATIO:     ratio_r   <= cfg_data[WW-1:0];
        default: ;
      endcase
    end
  end

  assign cnt = (32'(thr_cnt_r) > THREADS) ? CW'(THREADS) : CW'(thr_cnt_r);

  // ---------------------------------------------------------------- intake
  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_thread_r    <= in_tdata[2:0];
      req_ev_r.stamp  <= in_tdata[66:3];
      req_ev_r.kind   <= in_tdata[98:67];
      req_ev_r.value  <= in_tdata[130:99];
    end
  end

  // ---------------------------------------------------------------- pointers
  // one read index: load thread while loading, scan position otherwise
  assign ptr_idx  = (state_r == S_LOAD) ? TW'(req_thread_r) : scan_idx_r[TW-1:0];
  assign ptr_head = head_r[ptr_idx];
  assign ptr_fill = fill_r[ptr_idx];

  assign ld_ok   = (32'(req_thread_r) < 32'(cnt)) && (32'(ptr_fill) < QUEUE_DEPTH);
  assign pos_sum = (FW + 1)'(ptr_head) + (FW + 1)'(ptr_fill);
  assign wr_pos  = (pos_sum >= (FW + 1)'(QUEUE_DEPTH)) ?
                   PW'(pos_sum - (FW + 1)'(QUEUE_DEPTH)) : PW'(pos_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < THREADS; i++) begin
        head_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else if (state_r == S_LOAD && ld_ok) begin
      fill_r[ptr_idx] <= ptr_fill + FW'(1);
    end else if (state_r == S_DRAIN && found_r) begin
      head_r[best_idx_r] <= (32'(best_head_r) == QUEUE_DEPTH - 1) ?
                            '0 : best_head_r + PW'(1);
      fill_r[best_idx_r] <= best_fill_r - FW'(1);
    end
  end

  // ---------------------------------------------------------------- event ram
  // writes happen only in the load state and reads only in the scan, so
  // an entry is never read and written in the same cycle
  assign ram_we    = (state_r == S_LOAD) && ld_ok;
  assign ram_waddr = {ptr_idx, wr_pos};
  assign ram_re    = (state_r == S_SCAN) && (scan_idx_r < cnt) && (ptr_fill != '0);
  assign ram_raddr = {ptr_idx, ptr_head};

  kwm_ram #(
    .WIDTH (kwm_pkg::EVENT_W),
    .DEPTH (MEM_DEPTH)
  ) u_event_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req_ev_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_ev = kwm_pkg::event_t'(ram_rdata);

  // ---------------------------------------------------------------- head scan
  // strict compare in thread order keeps ties on the lowest thread
  assign take = pend_valid_r && (!found_r || (rd_ev.stamp < best_ev_r.stamp));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      found_r      <= 1'b0;
      scan_idx_r   <= '0;
    end else begin
      pend_valid_r <= ram_re;
      if (in_tvalid && in_tready) begin
        found_r    <= 1'b0;
        scan_idx_r <= '0;
      end else begin
        if (state_r == S_SCAN && scan_idx_r < cnt) begin
          scan_idx_r <= scan_idx_r + CW'(1);
        end
        if (take) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      pend_idx_r  <= ptr_idx;
      pend_head_r <= ptr_head;
      pend_fill_r <= ptr_fill;
    end
    if (take) begin
      best_idx_r  <= pend_idx_r;
      best_head_r <= pend_head_r;
      best_fill_r <= pend_fill_r;
      best_ev_r   <= rd_ev;
    end
  end

  // ---------------------------------------------------------------- scaling
  assign sc_start = (state_r == S_DRAIN) && found_r;

  kwm_scale #(
    .RATIO_FRAC (RATIO_FRAC)
  ) u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sc_start),
    .stamp (best_ev_r.stamp),
    .base  (start_r),
    .ratio (ratio_r),
    .done  (sc_done),
    .ns    (sc_ns)
  );

  // ---------------------------------------------------------------- control
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (in_tuser[0] == kwm_pkg::REQ_POP) ? S_SCAN : S_LOAD;
        end
      end
      S_LOAD:  state_nxt = S_OUT;
      S_SCAN: begin
        if (scan_idx_r >= cnt) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = found_r ? S_SCALE : S_OUT;
      S_SCALE: begin
        if (sc_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_LOAD || (state_r == S_DRAIN && !found_r)) begin
      res_thread_r <= '0;
      res_ns_r     <= '0;
      res_type_r   <= '0;
      res_value_r  <= '0;
    end
    if (state_r == S_LOAD) begin
      res_status_r <= ld_ok ? kwm_pkg::ST_LOADED : kwm_pkg::ST_REJECTED;
    end else if (state_r == S_DRAIN && !found_r) begin
      res_status_r <= kwm_pkg::ST_EMPTY;
    end else if (state_r == S_SCALE && sc_done) begin
      res_status_r <= kwm_pkg::ST_DELIVERED;
      res_thread_r <= kwm_pkg::TNUM_W'({1'b0, best_idx_r} + (TW + 1)'(1));
      res_ns_r     <= sc_ns;
      res_type_r   <= best_ev_r.kind;
      res_value_r  <= best_ev_r.value;
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_user_r <= res_status_r;
      out_data_r <= {4'b0, res_value_r, res_type_r, res_ns_r, res_thread_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // ---------------------------------------------------------------- checks
  a_ram_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("event ram read and written in one cycle");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second request taken while one is in work");

  a_scale_done: assert property (@(posedge clk) disable iff (!rst_n)
    sc_done |-> (state_r == S_SCALE))
    else $error("scaler finished outside the scale wait");

  a_load_fits: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (ptr_fill < FW'(QUEUE_DEPTH)))
    else $error("load written into a full queue");

endmodule
